// File: design/stuffed_frame_deframer_crc16_assert.svh
// ----------------------------------------------------------------------------
// Assertion helpers for the stuffed frame deframer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_DEFRAMER_CRC16_ASSERT_SVH
`define STUFFED_FRAME_DEFRAMER_CRC16_ASSERT_SVH

// same-cycle implication
`define SFD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/sfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg
// Types, constants and the CRC-16 byte update shared by the deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

	localparam logic [7:0] MAX_LEN    = 8'd128;
	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_FLIP   = 8'h20;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;

	typedef enum logic [7:0] {
		PH_WAIT = 8'b0000_0001,
		PH_ADDR = 8'b0000_0010,
		PH_KIND = 8'b0000_0100,
		PH_SEQ  = 8'b0000_1000,
		PH_LEN  = 8'b0001_0000,
		PH_PAY  = 8'b0010_0000,
		PH_CRCL = 8'b0100_0000,
		PH_CRCH = 8'b1000_0000
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD    = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_TOO_LONG = 2'd2,
		ST_ABORT   = 2'd3
	} status_t;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	typedef struct packed {
		logic       hit;
		logic       kind;
		logic [7:0] data;
		logic [1:0] status;
		logic [7:0] dest_addr;
		logic [7:0] frame_kind;
		logic [7:0] seq_no;
		logic [7:0] pay_len;
		logic       last_of_frame;
	} result_t;

	// reflected CRC-16, one byte
	function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// File: design/sfd_rx_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_rx_if
// Raw line byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface sfd_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

// File: design/sfd_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_res_if
// Result channel: payload bytes and frame end reports, valid/ready.
// ----------------------------------------------------------------------------
interface sfd_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data;
	logic [1:0] status;
	logic [7:0] dest_addr;
	logic [7:0] frame_kind;
	logic [7:0] seq_no;
	logic [7:0] pay_len;
	logic       last_of_frame;

	modport source (output valid, output kind, output data, output status,
		output dest_addr, output frame_kind, output seq_no, output pay_len,
		output last_of_frame, input ready);
	modport sink (input valid, input kind, input data, input status,
		input dest_addr, input frame_kind, input seq_no, input pay_len,
		input last_of_frame, output ready);
endinterface

// File: design/stuffed_frame_deframer_crc16.sv
`timescale 1ns / 1ps
// A result is registered in the result register after its byte leaves the input register.
// Throughput: one line byte per cycle unless results back up; a no-result byte still uses a step.
// The input register is freed whenever the result register is empty or being read.
// Reset (arst_n low) empties both registers and returns the parser to waiting for a start byte.
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_crc16
// Byte-stuffed frame receiver with CRC-16 check, one raw byte per transfer.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_crc16 import sfd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	sfd_rx_if.sink    rx,
	sfd_res_if.source res
);

	logic       step;
	logic       out_free;
	logic [7:0] byte_s1;
	result_t    rslt;

	sfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx       (rx),
		.out_free (out_free),
		.step     (step),
		.rx_byte  (byte_s1)
	);

	sfd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (byte_s1),
		.rslt    (rslt)
	);

	sfd_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.rslt     (rslt),
		.out_free (out_free),
		.res      (res)
	);

endmodule

// File: design/sfd_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_in_reg
// Input register: holds one raw byte until the parser can take it.
// ----------------------------------------------------------------------------
module sfd_in_reg import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	sfd_rx_if.sink     rx,
	input  logic       out_free,
	output logic       step,
	output logic [7:0] rx_byte
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign step     = valid_s1 && out_free;
	assign rx.ready = !valid_s1 || out_free;
	assign rx_byte  = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

endmodule

// File: design/sfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core
// Destuffing, header parse, CRC update and frame status for one byte.
// ----------------------------------------------------------------------------
`include "stuffed_frame_deframer_crc16_assert.svh"

module sfd_core import sfd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	output result_t    rslt
);

	phase_t      phase_q, phase_n;
	logic        esc_q, esc_n;
	logic [7:0]  addr_q, addr_n;
	logic [7:0]  kind_q, kind_n;
	logic [7:0]  seq_q, seq_n;
	logic [7:0]  len_q, len_n;
	logic [7:0]  cnt_q, cnt_n;
	logic [15:0] crc_q, crc_n;
	logic [7:0]  crcl_q, crcl_n;

	logic [7:0]  b_eff;
	logic [15:0] crc_upd;
	logic [7:0]  cnt_inc;

	function automatic result_t make_report(input logic [1:0] st, input logic [7:0] a,
		input logic [7:0] k, input logic [7:0] s, input logic [7:0] l);
		result_t r;
		r               = '0;
		r.hit           = 1'b1;
		r.kind          = KIND_REPORT;
		r.status        = st;
		r.dest_addr     = a;
		r.frame_kind    = k;
		r.seq_no        = s;
		r.pay_len       = l;
		r.last_of_frame = 1'b1;
		return r;
	endfunction

	assign b_eff   = esc_q ? (rx_byte ^ ESC_FLIP) : rx_byte;
	assign crc_upd = crc16_step(crc_q, b_eff);
	assign cnt_inc = cnt_q + 8'd1;

	always_comb begin
		phase_n = phase_q;
		esc_n   = esc_q;
		addr_n  = addr_q;
		kind_n  = kind_q;
		seq_n   = seq_q;
		len_n   = len_q;
		cnt_n   = cnt_q;
		crc_n   = crc_q;
		crcl_n  = crcl_q;
		rslt    = '0;

		if (rx_byte == START_BYTE) begin
			// start byte mid-frame closes the old frame as aborted
			if (phase_q != PH_WAIT && phase_q != PH_ADDR) begin
				rslt = make_report(ST_ABORT, addr_q, kind_q, seq_q, len_q);
			end
			phase_n = PH_ADDR;
			esc_n   = 1'b0;
			addr_n  = '0;
			kind_n  = '0;
			seq_n   = '0;
			len_n   = '0;
			cnt_n   = '0;
			crc_n   = CRC_INIT;
			crcl_n  = '0;
		end else if (phase_q == PH_WAIT) begin
			// idle byte, dropped
		end else if (!esc_q && rx_byte == ESC_BYTE) begin
			esc_n = 1'b1;
		end else begin
			esc_n = 1'b0;
			case (phase_q)
				PH_ADDR: begin
					addr_n  = b_eff;
					crc_n   = crc_upd;
					phase_n = PH_KIND;
				end
				PH_KIND: begin
					kind_n  = b_eff;
					crc_n   = crc_upd;
					phase_n = PH_SEQ;
				end
				PH_SEQ: begin
					seq_n   = b_eff;
					crc_n   = crc_upd;
					phase_n = PH_LEN;
				end
				PH_LEN: begin
					len_n = b_eff;
					if (b_eff > MAX_LEN) begin
						rslt    = make_report(ST_TOO_LONG, addr_q, kind_q, seq_q, b_eff);
						phase_n = PH_WAIT;
					end else begin
						crc_n   = crc_upd;
						cnt_n   = '0;
						phase_n = (b_eff == 8'd0) ? PH_CRCL : PH_PAY;
					end
				end
				PH_PAY: begin
					crc_n = crc_upd;
					cnt_n = cnt_inc;
					if (cnt_inc >= len_q) begin
						phase_n = PH_CRCL;
					end
					rslt.hit  = 1'b1;
					rslt.kind = KIND_PAYLOAD;
					rslt.data = b_eff;
				end
				PH_CRCL: begin
					crcl_n  = b_eff;
					phase_n = PH_CRCH;
				end
				PH_CRCH: begin
					rslt = make_report(({b_eff, crcl_q} == crc_q) ? ST_GOOD : ST_CRC_BAD,
						addr_q, kind_q, seq_q, len_q);
					phase_n = PH_WAIT;
				end
				default: begin
					phase_n = PH_WAIT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			esc_q   <= 1'b0;
			addr_q  <= '0;
			kind_q  <= '0;
			seq_q   <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			crc_q   <= CRC_INIT;
			crcl_q  <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			esc_q   <= esc_n;
			addr_q  <= addr_n;
			kind_q  <= kind_n;
			seq_q   <= seq_n;
			len_q   <= len_n;
			cnt_q   <= cnt_n;
			crc_q   <= crc_n;
			crcl_q  <= crcl_n;
		end
	end

	`SFD_ASSERT_NXT(a_start_opens, step && rx_byte == START_BYTE, phase_q == PH_ADDR && !esc_q && crc_q == CRC_INIT, "start byte did not open a frame")
	`SFD_ASSERT_IMP(a_wait_no_esc, phase_q == PH_WAIT, !esc_q, "escape pending while waiting for start")
	`SFD_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= len_q, "payload count ran past length")
	`SFD_ASSERT_IMP(a_pay_len_ok, phase_q == PH_PAY, len_q != 8'd0 && len_q <= MAX_LEN, "payload phase with bad length")

endmodule

// File: design/sfd_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_out_reg
// Result register driving the result channel.
// ----------------------------------------------------------------------------
module sfd_out_reg import sfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  result_t rslt,
	output logic    out_free,
	sfd_res_if.source res
);

	logic    valid_q;
	result_t res_q;

	assign out_free          = !valid_q || res.ready;
	assign res.valid         = valid_q;
	assign res.kind          = res_q.kind;
	assign res.data          = res_q.data;
	assign res.status        = res_q.status;
	assign res.dest_addr     = res_q.dest_addr;
	assign res.frame_kind    = res_q.frame_kind;
	assign res.seq_no        = res_q.seq_no;
	assign res.pay_len       = res_q.pay_len;
	assign res.last_of_frame = res_q.last_of_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= rslt.hit;
		end else if (res.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && rslt.hit) begin
			res_q <= rslt;
		end
	end

endmodule

// File: tb/stuffed_frame_deframer_crc16_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_crc16_tb
// Drives byte-stuffed line traffic into the deframer: good frames, CRC errors,
// oversize lengths, cut frames and idle noise. A behavioral deframer in the
// bench predicts every payload byte and frame end report, and a monitor
// checks each result transfer field by field. Random idle gaps on the line
// channel and random backpressure on the result channel.
// ----------------------------------------------------------------------------
module stuffed_frame_deframer_crc16_tb;
	import sfd_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [1:0] status;
		logic [7:0] dest_addr;
		logic [7:0] frame_kind;
		logic [7:0] seq_no;
		logic [7:0] pay_len;
		logic       last_of_frame;
	} deframe_out_t;

	localparam int CALM_TAIL = 120;  // last line bytes go out without idling

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	sfd_rx_if rx_ch ();
	sfd_res_if res_ch ();

	stuffed_frame_deframer_crc16 dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_ch),
		.res    (res_ch)
	);

	always #6 clk = ~clk;

	logic [7:0]   line_q[$];      // stuffed bytes still to send
	deframe_out_t deframed_q[$];  // predicted results not yet seen
	int           fails = 0;
	int           tx_gap;
	int           rx_stall;

	// receiver state of the bench deframer
	phase_t      ph;
	logic        esc_pend;
	logic [7:0]  h_addr, h_kind, h_seq, h_len, pay_cnt, crc_lo;
	logic [15:0] crc_acc;

	function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		r = acc ^ {8'h00, b};
		repeat (8) r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
		return r;
	endfunction

	task automatic clear_frame();
		esc_pend = 1'b0;
		h_addr = '0;
		h_kind = '0;
		h_seq = '0;
		h_len = '0;
		pay_cnt = '0;
		crc_acc = CRC_INIT;
		crc_lo = '0;
	endtask

	task automatic push_report(input status_t st);
		deframe_out_t r;
		r = '0;
		r.kind = KIND_REPORT;
		r.status = st;
		r.dest_addr = h_addr;
		r.frame_kind = h_kind;
		r.seq_no = h_seq;
		r.pay_len = h_len;
		r.last_of_frame = 1'b1;
		deframed_q.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] raw);
		logic [7:0]   b;
		deframe_out_t r;
		b = raw;
		if (raw == START_BYTE) begin
			// start inside a frame aborts it once a frame byte has been taken
			if (ph != PH_WAIT && ph != PH_ADDR)
				push_report(ST_ABORT);
			clear_frame();
			ph = PH_ADDR;
			return;
		end
		if (ph == PH_WAIT)
			return;
		if (esc_pend) begin
			b = raw ^ ESC_FLIP;
			esc_pend = 1'b0;
		end else if (raw == ESC_BYTE) begin
			esc_pend = 1'b1;
			return;
		end
		case (ph)
			PH_ADDR: begin
				h_addr = b;
				crc_acc = crc16_modbus(crc_acc, b);
				ph = PH_KIND;
			end
			PH_KIND: begin
				h_kind = b;
				crc_acc = crc16_modbus(crc_acc, b);
				ph = PH_SEQ;
			end
			PH_SEQ: begin
				h_seq = b;
				crc_acc = crc16_modbus(crc_acc, b);
				ph = PH_LEN;
			end
			PH_LEN: begin
				h_len = b;
				if (b > MAX_LEN) begin
					push_report(ST_TOO_LONG);
					ph = PH_WAIT;
					esc_pend = 1'b0;
				end else begin
					crc_acc = crc16_modbus(crc_acc, b);
					pay_cnt = '0;
					ph = (b == 8'd0) ? PH_CRCL : PH_PAY;
				end
			end
			PH_PAY: begin
				crc_acc = crc16_modbus(crc_acc, b);
				pay_cnt = pay_cnt + 8'd1;
				if (pay_cnt >= h_len)
					ph = PH_CRCL;
				r = '0;
				r.kind = KIND_PAYLOAD;
				r.data = b;
				deframed_q.push_back(r);
			end
			PH_CRCL: begin
				crc_lo = b;
				ph = PH_CRCH;
			end
			default: begin
				push_report(({b, crc_lo} == crc_acc) ? ST_GOOD : ST_CRC_BAD);
				ph = PH_WAIT;
				esc_pend = 1'b0;
			end
		endcase
	endtask

	task automatic check_field(input string name, input logic [7:0] want_v,
		input logic [7:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, got %0h", name, want_v, got_v);
			fails++;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic logic [7:0] pick_byte();
		logic [7:0] specials[6];
		specials = '{8'h7E, 8'h7D, 8'h5E, 8'h5D, 8'h00, 8'hFF};
		if ($urandom_range(0, 5) == 0)
			return specials[$urandom_range(0, 5)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] pick_len();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return 8'($urandom_range(0, 8));
		if (sel < 9)
			return 8'($urandom_range(9, 40));
		return 8'($urandom_range(41, MAX_LEN));
	endfunction

	task automatic push_raw(input logic [7:0] b);
		line_q.push_back(b);
	endtask

	// stuff one frame byte; 0x5D always goes out as an escaped escape,
	// other bytes are sometimes escaped without need (never 0x5E, which
	// would put a raw start byte on the line)
	task automatic push_logical(input logic [7:0] b);
		if (b == START_BYTE || b == ESC_BYTE || b == 8'h5D ||
			(b != 8'h5E && $urandom_range(0, 15) == 0)) begin
			push_raw(ESC_BYTE);
			push_raw(b ^ ESC_FLIP);
		end else begin
			push_raw(b);
		end
	endtask

	// cut < 0 sends the whole frame; fill < 0 gives random payload
	task automatic push_frame(input logic [7:0] a, input logic [7:0] k, input logic [7:0] s,
		input logic [7:0] l, input int cut, input bit bad_crc, input bit dangling_esc,
		input int fill);
		logic [7:0]  body[$];
		logic [15:0] c;
		int          n;
		body.push_back(a);
		body.push_back(k);
		body.push_back(s);
		body.push_back(l);
		if (l <= MAX_LEN) begin
			for (int i = 0; i < l; i++)
				body.push_back((fill < 0) ? pick_byte() : fill[7:0]);
			c = CRC_INIT;
			foreach (body[i])
				c = crc16_modbus(c, body[i]);
			if (bad_crc)
				c = c ^ (16'h0001 << $urandom_range(0, 15));
			body.push_back(c[7:0]);
			body.push_back(c[15:8]);
		end
		n = (cut >= 0 && cut < body.size()) ? cut : body.size();
		push_raw(START_BYTE);
		for (int i = 0; i < n; i++)
			push_logical(body[i]);
		if (dangling_esc)
			push_raw(ESC_BYTE);
	endtask

	// ---------------- line side driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_ch.valid <= 1'b0;
			rx_ch.rx_byte <= '0;
			tx_gap <= 0;
			ph = PH_WAIT;
			clear_frame();
		end else begin
			if (rx_ch.valid && rx_ch.ready)
				deframe_byte(rx_ch.rx_byte);
			if (!rx_ch.valid || rx_ch.ready) begin
				if (tx_gap > 0) begin
					tx_gap <= tx_gap - 1;
					rx_ch.valid <= 1'b0;
				end else if (line_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
					tx_gap <= $urandom_range(0, 3);
					rx_ch.valid <= 1'b0;
				end else if (line_q.size() > 0) begin
					rx_ch.valid <= 1'b1;
					rx_ch.rx_byte <= line_q.pop_front();
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------

	always @(posedge clk or negedge arst_n) begin : res_monitor
		deframe_out_t want;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (deframed_q.size() == 0) begin
					$error("unexpected result transfer: kind %0b data %0h status %0d",
						res_ch.kind, res_ch.data, res_ch.status);
					fails++;
				end else begin
					want = deframed_q.pop_front();
					check_field("kind", 8'(want.kind), 8'(res_ch.kind));
					check_field("data", want.data, res_ch.data);
					check_field("status", 8'(want.status), 8'(res_ch.status));
					check_field("dest_addr", want.dest_addr, res_ch.dest_addr);
					check_field("frame_kind", want.frame_kind, res_ch.frame_kind);
					check_field("seq_no", want.seq_no, res_ch.seq_no);
					check_field("pay_len", want.pay_len, res_ch.pay_len);
					check_field("last_of_frame", 8'(want.last_of_frame),
						8'(res_ch.last_of_frame));
				end
			end
			if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				res_ch.ready <= 1'b0;
			end else if (line_q.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
				rx_stall <= $urandom_range(0, 3);
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int sel;
		logic [7:0] l;

		rx_ch.valid = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready = 1'b0;

		// idle noise, including a lone escape, is dropped before any start
		push_raw(8'h00);
		push_raw(ESC_BYTE);
		push_raw(8'hFF);
		// back-to-back starts and a start after a pending escape: no report
		push_raw(START_BYTE);
		push_raw(START_BYTE);
		push_raw(ESC_BYTE);
		push_frame(8'h7E, 8'h7D, 8'hFF, 8'h00, -1, 1'b0, 1'b0, -1);  // zero length
		push_frame(8'h00, 8'hFF, 8'h5D, 8'h03, -1, 1'b0, 1'b0, 8'h5D); // escaped escapes
		push_frame(8'hFF, 8'h00, 8'h7E, 8'h02, -1, 1'b1, 1'b0, 8'h7E); // bad CRC
		push_frame(8'h11, 8'h22, 8'h33, MAX_LEN + 8'd1, -1, 1'b0, 1'b0, -1);
		push_raw(8'hAA);
		push_frame(8'h44, 8'h55, 8'h66, 8'hFF, -1, 1'b0, 1'b0, -1);
		push_frame(8'h01, 8'h02, 8'h03, 8'h04, 2, 1'b0, 1'b0, -1);     // abort after type
		push_frame(8'h01, 8'h02, 8'h03, 8'h04, 0, 1'b0, 1'b1, -1);     // start, escape, start
		push_frame(8'hA5, 8'h5A, 8'hC3, 8'h01, 4, 1'b0, 1'b0, -1);     // abort after length
		push_frame(8'h0F, 8'hF0, 8'h3C, 8'h06, 6, 1'b0, 1'b1, -1);     // abort mid escape
		push_frame(8'h80, 8'h7F, 8'h01, 8'h01, -1, 1'b0, 1'b0, -1);

		// largest payload, good and corrupted
		push_frame(pick_byte(), pick_byte(), pick_byte(), MAX_LEN, -1, 1'b0, 1'b0, -1);
		push_frame(pick_byte(), pick_byte(), pick_byte(), MAX_LEN, -1, 1'b1, 1'b0, -1);

		while (line_q.size() < 1040) begin
			sel = $urandom_range(0, 99);
			l = pick_len();
			if (sel < 68)
				push_frame(pick_byte(), pick_byte(), pick_byte(), l, -1, 1'b0, 1'b0, -1);
			else if (sel < 78)
				push_frame(pick_byte(), pick_byte(), pick_byte(), l, -1, 1'b1, 1'b0, -1);
			else if (sel < 86)
				push_frame(pick_byte(), pick_byte(), pick_byte(), l,
					$urandom_range(0, 5 + l), 1'b0, 1'($urandom_range(0, 1)), -1);
			else if (sel < 93)
				push_frame(pick_byte(), pick_byte(), pick_byte(),
					8'($urandom_range(MAX_LEN + 1, 255)), -1, 1'b0, 1'b0, -1);
			else
				repeat ($urandom_range(1, 5)) push_raw(pick_byte());
		end
		// closing frame settles anything left open
		push_frame(pick_byte(), pick_byte(), pick_byte(), 8'h03, -1, 1'b0, 1'b0, -1);

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (line_q.size() != 0 || rx_ch.valid) @(posedge clk);
		while (deframed_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (fails == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#3000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// File: stuffed_frame_deframer_crc16.f
+incdir+design
design/sfd_pkg.sv
design/sfd_rx_if.sv
design/sfd_res_if.sv
design/sfd_in_reg.sv
design/sfd_core.sv
design/sfd_out_reg.sv
design/stuffed_frame_deframer_crc16.sv
tb/stuffed_frame_deframer_crc16_tb.sv
